### rtl/sgr_pkg.sv
// Shared types, constants and font ROM for the scaled glyph rasterizer.
package sgr_pkg;

    localparam int GLYPH_ROWS  = 7;
    localparam int GLYPH_COLS  = 5;
    localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
    localparam int GLYPH_COUNT = 36;
    localparam int POS_W       = 14;

    localparam logic [7:0] CODE_A     = 8'h41;
    localparam logic [7:0] CODE_Z     = 8'h5A;
    localparam logic [7:0] CODE_0     = 8'h30;
    localparam logic [7:0] CODE_9     = 8'h39;
    localparam logic [5:0] DIGIT_BASE = 6'd26;
    localparam logic [2:0] LAST_COL   = 3'(GLYPH_COLS - 1);

    typedef logic [GLYPH_BITS-1:0] glyph_t;
    typedef logic [5:0] glyph_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic code_ok;
        logic cell_set;
        logic rest_empty;
        logic out_free;
    } ctrl_status_t;

    // Rows top to bottom, bit 4 of each row is the left column; MSB is the first cell.
    localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
        {5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
        {5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
        {5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
        {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
        {5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
        {5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd15},
        {5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
        {5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        {5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
        {5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
        {5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
        {5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
        {5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
        {5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
        {5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
        {5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
        {5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
        {5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
        {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
        {5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
        {5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
        {5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
        {5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
        {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31},
        {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
        {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
        {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
        {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
        {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
        {5'd31, 5'd16, 5'd30, 5'd1,  5'd1,  5'd17, 5'd14},
        {5'd6,  5'd8,  5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
        {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
        {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
        {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd2,  5'd12}
    };

endpackage

### rtl/sgr_ctrl.sv
// Controller state machine: accepts a request and paces the cell scan.
module sgr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sgr_pkg::ctrl_status_t status,
    output sgr_pkg::ctrl_cmd_t    cmd
);

    sgr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            sgr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && status.code_ok) begin
                    cmd.load   = 1'b1;
                    state_next = sgr_pkg::ST_SCAN;
                end
            end
            sgr_pkg::ST_SCAN: begin
                cmd.step = !status.cell_set || status.out_free;
                if (cmd.step && status.rest_empty) begin
                    state_next = sgr_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sgr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/sgr_datapath.sv
// Datapath: font lookup, cell scan positions, clipping and the result register.
module sgr_datapath #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sgr_pkg::ctrl_cmd_t     cmd,
    output sgr_pkg::ctrl_status_t  status,
    input  logic [7:0]            s_char_code,
    input  logic signed [11:0]    s_origin_x,
    input  logic signed [11:0]    s_origin_y,
    input  logic [7:0]            s_ink,
    input  logic [3:0]            s_scale,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [8:0]            m_rect_x,
    output logic [7:0]            m_rect_y,
    output logic [3:0]            m_rect_w,
    output logic [3:0]            m_rect_h,
    output logic [7:0]            m_fill_ink,
    output logic                  m_visible,
    output logic                  m_last
);

    localparam int PW = sgr_pkg::POS_W;
    localparam logic signed [PW-1:0] X_LIMIT = PW'(SCREEN_WIDTH);
    localparam logic signed [PW-1:0] Y_LIMIT = PW'(SCREEN_HEIGHT);

    logic                  code_ok;
    sgr_pkg::glyph_idx_t   glyph_idx;

    sgr_pkg::glyph_t       mask_reg, mask_next;
    logic [2:0]            col_reg, col_next;
    logic signed [PW-1:0]  ox_reg, ox_next;
    logic signed [PW-1:0]  cur_x_reg, cur_x_next;
    logic signed [PW-1:0]  cur_y_reg, cur_y_next;
    logic [3:0]            sc_reg, sc_next;
    logic [7:0]            ink_reg, ink_next;

    logic                  out_valid_reg, out_valid_next;
    logic [8:0]            rect_x_reg, rect_x_next;
    logic [7:0]            rect_y_reg, rect_y_next;
    logic [3:0]            rect_w_reg, rect_w_next;
    logic [3:0]            rect_h_reg, rect_h_next;
    logic [7:0]            ink_out_reg, ink_out_next;
    logic                  visible_reg, visible_next;
    logic                  last_reg, last_next;

    logic signed [PW-1:0]  sc_s;
    logic signed [PW-1:0]  px, py, lx, ly;
    logic                  rest_empty;
    logic                  show;

    always_comb begin
        code_ok   = 1'b0;
        glyph_idx = '0;
        if (s_char_code >= sgr_pkg::CODE_A && s_char_code <= sgr_pkg::CODE_Z) begin
            code_ok   = 1'b1;
            glyph_idx = 6'(s_char_code - sgr_pkg::CODE_A);
        end else if (s_char_code >= sgr_pkg::CODE_0 && s_char_code <= sgr_pkg::CODE_9) begin
            code_ok   = 1'b1;
            glyph_idx = sgr_pkg::DIGIT_BASE + 6'(s_char_code - sgr_pkg::CODE_0);
        end
    end

    assign sc_s       = $signed({{(PW-4){1'b0}}, sc_reg});
    assign rest_empty = ~|mask_reg[sgr_pkg::GLYPH_BITS-2:0];

    always_comb begin
        px = cur_x_reg;
        lx = sc_s;
        if (px < 0) begin
            lx = lx + px;
            px = '0;
        end
        if (px + lx > X_LIMIT) begin
            lx = X_LIMIT - px;
        end
        py = cur_y_reg;
        ly = sc_s;
        if (py < 0) begin
            ly = ly + py;
            py = '0;
        end
        if (py + ly > Y_LIMIT) begin
            ly = Y_LIMIT - py;
        end
        show = (lx > 0) && (ly > 0);
    end

    always_comb begin
        status.code_ok    = code_ok;
        status.cell_set   = mask_reg[sgr_pkg::GLYPH_BITS-1];
        status.rest_empty = rest_empty;
        status.out_free   = !out_valid_reg || m_ready;
    end

    always_comb begin
        mask_next  = mask_reg;
        col_next   = col_reg;
        ox_next    = ox_reg;
        cur_x_next = cur_x_reg;
        cur_y_next = cur_y_reg;
        sc_next    = sc_reg;
        ink_next   = ink_reg;
        if (cmd.load) begin
            mask_next  = sgr_pkg::GLYPH_ROM[glyph_idx];
            col_next   = '0;
            ox_next    = PW'(s_origin_x);
            cur_x_next = PW'(s_origin_x);
            cur_y_next = PW'(s_origin_y);
            sc_next    = s_scale;
            ink_next   = s_ink;
        end else if (cmd.step) begin
            mask_next = {mask_reg[sgr_pkg::GLYPH_BITS-2:0], 1'b0};
            if (col_reg == sgr_pkg::LAST_COL) begin
                col_next   = '0;
                cur_x_next = ox_reg;
                cur_y_next = cur_y_reg + sc_s;
            end else begin
                col_next   = col_reg + 3'd1;
                cur_x_next = cur_x_reg + sc_s;
            end
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg && !m_ready;
        rect_x_next    = rect_x_reg;
        rect_y_next    = rect_y_reg;
        rect_w_next    = rect_w_reg;
        rect_h_next    = rect_h_reg;
        ink_out_next   = ink_out_reg;
        visible_next   = visible_reg;
        last_next      = last_reg;
        if (cmd.step && mask_reg[sgr_pkg::GLYPH_BITS-1]) begin
            out_valid_next = 1'b1;
            rect_x_next    = show ? px[8:0] : '0;
            rect_y_next    = show ? py[7:0] : '0;
            rect_w_next    = show ? lx[3:0] : '0;
            rect_h_next    = show ? ly[3:0] : '0;
            ink_out_next   = ink_reg;
            visible_next   = show;
            last_next      = rest_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg    <= mask_next;
        col_reg     <= col_next;
        ox_reg      <= ox_next;
        cur_x_reg   <= cur_x_next;
        cur_y_reg   <= cur_y_next;
        sc_reg      <= sc_next;
        ink_reg     <= ink_next;
        rect_x_reg  <= rect_x_next;
        rect_y_reg  <= rect_y_next;
        rect_w_reg  <= rect_w_next;
        rect_h_reg  <= rect_h_next;
        ink_out_reg <= ink_out_next;
        visible_reg <= visible_next;
        last_reg    <= last_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_rect_x   = rect_x_reg;
    assign m_rect_y   = rect_y_reg;
    assign m_rect_w   = rect_w_reg;
    assign m_rect_h   = rect_h_reg;
    assign m_fill_ink = ink_out_reg;
    assign m_visible  = visible_reg;
    assign m_last     = last_reg;

endmodule

### rtl/scaled_glyph_rasterizer.sv
// A request loads the glyph mask; each set cell in the scan then loads the result register.
// A new request is taken only once the scan is done; the scan steps one cell per cycle, stops after
// the last set cell, and waits on a set cell while the result register is still held.
// Unknown codes are accepted and give no beats.
// Reset (aresetn low, synchronous) returns the controller to idle and empties the result register.
module scaled_glyph_rasterizer #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 200
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_char_code,
    input  logic signed [11:0] s_origin_x,
    input  logic signed [11:0] s_origin_y,
    input  logic [7:0]         s_ink,
    input  logic [3:0]         s_scale,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [8:0]         m_rect_x,
    output logic [7:0]         m_rect_y,
    output logic [3:0]         m_rect_w,
    output logic [3:0]         m_rect_h,
    output logic [7:0]         m_fill_ink,
    output logic               m_visible,
    output logic               m_last
);

    sgr_pkg::ctrl_cmd_t    cmd;
    sgr_pkg::ctrl_status_t status;

    sgr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sgr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_char_code (s_char_code),
        .s_origin_x  (s_origin_x),
        .s_origin_y  (s_origin_y),
        .s_ink       (s_ink),
        .s_scale     (s_scale),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_rect_x    (m_rect_x),
        .m_rect_y    (m_rect_y),
        .m_rect_w    (m_rect_w),
        .m_rect_h    (m_rect_h),
        .m_fill_ink  (m_fill_ink),
        .m_visible   (m_visible),
        .m_last      (m_last)
    );

endmodule

### verif/scaled_glyph_rasterizer_tb.sv
// Testbench for scaled_glyph_rasterizer: directed and random draw requests vs. a predictor.
module scaled_glyph_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DISP_W        = 320;
    localparam int DISP_H        = 200;
    localparam int RANDOM_GLYPHS = 355;
    localparam int LONG_HOLD     = 400;

    localparam logic [0:6][4:0] FONT_ROWS [36] = '{
        '{14,17,17,31,17,17,17}, '{30,17,17,30,17,17,30}, '{14,17,16,16,16,17,14},
        '{30,17,17,17,17,17,30}, '{31,16,16,30,16,16,31}, '{31,16,16,30,16,16,16},
        '{14,17,16,23,17,17,15}, '{17,17,17,31,17,17,17}, '{14,4,4,4,4,4,14},
        '{7,2,2,2,18,18,12},     '{17,18,20,24,20,18,17}, '{16,16,16,16,16,16,31},
        '{17,27,21,21,17,17,17}, '{17,25,21,19,17,17,17}, '{14,17,17,17,17,17,14},
        '{30,17,17,30,16,16,16}, '{14,17,17,17,21,18,13}, '{30,17,17,30,20,18,17},
        '{15,16,16,14,1,1,30},   '{31,4,4,4,4,4,4},       '{17,17,17,17,17,17,14},
        '{17,17,17,17,17,10,4},  '{17,17,17,21,21,21,10}, '{17,17,10,4,10,17,17},
        '{17,17,10,4,4,4,4},     '{31,1,2,4,8,16,31},
        '{14,17,19,21,25,17,14}, '{4,12,4,4,4,4,14},      '{14,17,1,2,4,8,31},
        '{30,1,1,14,1,1,30},     '{2,6,10,18,31,2,2},     '{31,16,30,1,1,17,14},
        '{6,8,16,30,17,17,14},   '{31,1,2,4,8,8,8},       '{14,17,17,14,17,17,14},
        '{14,17,17,15,1,2,12}
    };

    typedef struct packed {
        logic [8:0] x;
        logic [7:0] y;
        logic [3:0] w;
        logic [3:0] h;
        logic [7:0] ink;
        logic       vis;
        logic       last;
    } glyph_rect_t;

    // cnt < 0: predictor only; otherwise count and first rectangle are typed in
    typedef struct {
        int code, ox, oy, ink, scale, cnt, fx, fy, fw, fh, fv;
    } draw_row_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_char_code;
    logic signed [11:0] s_origin_x;
    logic signed [11:0] s_origin_y;
    logic [7:0]         s_ink;
    logic [3:0]         s_scale;
    logic               m_valid;
    logic               m_ready;
    logic [8:0]         m_rect_x;
    logic [7:0]         m_rect_y;
    logic [3:0]         m_rect_w;
    logic [3:0]         m_rect_h;
    logic [7:0]         m_fill_ink;
    logic               m_visible;
    logic               m_last;

    glyph_rect_t pending_rects[$];
    int          errors = 0;
    int          glyph_reqs = 0;
    int          unknown_reqs = 0;
    int          rect_beats = 0;
    int          hidden_beats = 0;
    logic [35:0] glyphs_seen = '0;
    bit          wind_down = 1'b0;
    bit          hold_long_req = 1'b0;
    int          req_cnt, req_fx, req_fy, req_fw, req_fh, req_fv;

    draw_row_t draw_rows [24] = '{
        '{"A",      0,      0,   0,  1, 18,   1,   0, 1, 1, 1},
        '{"Z",  -2048,  -2048, 255,  8, 15,   0,   0, 0, 0, 0},
        '{"9",   2047,   2047,  90, 15, 15,   0,   0, 0, 0, 0},
        '{"0",    318,    198,  17,  4, 19,   0,   0, 0, 0, 0},
        '{"I",     -3,     -2, 200,  4, 11,   1,   0, 4, 2, 1},
        '{"M",     10,     10,  33,  0, 18,   0,   0, 0, 0, 0},
        '{"T",    316,    196, 165,  3, 11, 316, 196, 3, 3, 1},
        '{"1",    100,     50,   1,  9, 10, 118,  50, 9, 9, 1},
        '{"8",     -1,     -1, 128,  2, 17,   1,   0, 2, 1, 1},
        '{"L",      0,    193, 127,  1, 11,   0, 193, 1, 1, 1},
        '{"B",    312,    192,  64, 15, 20, 312, 192, 8, 8, 1},
        // codes just outside the font ranges, the byte extremes and a lower-case letter
        '{"@",      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{"[",      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{"/",      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{":",      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{0,        5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{255,      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{"a",      5,      5,   3,  1,  0,   0,   0, 0, 0, 0},
        '{"W",    304,    100,   9,  8, -1,   0,   0, 0, 0, 0},
        '{"K",    -20,    150,  77,  5, -1,   0,   0, 0, 0, 0},
        '{"Q",    200,    -30, 240,  6, -1,   0,   0, 0, 0, 0},
        '{"R",    150,     80,   3,  7, -1,   0,   0, 0, 0, 0},
        '{"X",  -2048,    100,  56, 11, -1,   0,   0, 0, 0, 0},
        '{"5",    290,    170, 250, 12, -1,   0,   0, 0, 0, 0}
    };

    scaled_glyph_rasterizer #(
        .SCREEN_WIDTH (DISP_W),
        .SCREEN_HEIGHT(DISP_H)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_char_code(s_char_code),
        .s_origin_x (s_origin_x),
        .s_origin_y (s_origin_y),
        .s_ink      (s_ink),
        .s_scale    (s_scale),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rect_x   (m_rect_x),
        .m_rect_y   (m_rect_y),
        .m_rect_w   (m_rect_w),
        .m_rect_h   (m_rect_h),
        .m_fill_ink (m_fill_ink),
        .m_visible  (m_visible),
        .m_last     (m_last)
    );

    initial aclk = 1'b0;
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Queues one clipped rectangle per set cell; returns how many were queued.
    function automatic int rasterize_glyph(logic [7:0] code, logic signed [11:0] ox,
                                           logic signed [11:0] oy, logic [7:0] ink,
                                           logic [3:0] scale);
        int slot, total, n, x, y, w, h, sz;
        glyph_rect_t entry;
        if (code >= "A" && code <= "Z") begin
            slot = int'(code) - "A";
        end else if (code >= "0" && code <= "9") begin
            slot = 26 + int'(code) - "0";
        end else begin
            return 0;
        end
        glyphs_seen[slot] = 1'b1;
        total = 0;
        for (int r = 0; r < 7; r++)
            for (int c = 0; c < 5; c++)
                if (FONT_ROWS[slot][r][4-c]) total++;
        sz = int'(scale);
        n = 0;
        for (int r = 0; r < 7; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (FONT_ROWS[slot][r][4-c]) begin
                    x = int'(ox) + c * sz;
                    y = int'(oy) + r * sz;
                    w = sz;
                    h = sz;
                    if (x < 0) begin
                        w += x;
                        x = 0;
                    end
                    if (y < 0) begin
                        h += y;
                        y = 0;
                    end
                    if (x + w > DISP_W) w = DISP_W - x;
                    if (y + h > DISP_H) h = DISP_H - y;
                    entry = '0;
                    if (w > 0 && h > 0) begin
                        entry.x = 9'(x);
                        entry.y = 8'(y);
                        entry.w = 4'(w);
                        entry.h = 4'(h);
                        entry.vis = 1'b1;
                    end
                    entry.ink = ink;
                    n++;
                    entry.last = (n == total);
                    pending_rects.push_back(entry);
                end
            end
        end
        return n;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : rect_check
        int n, k;
        glyph_rect_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                n = rasterize_glyph(s_char_code, s_origin_x, s_origin_y, s_ink, s_scale);
                if (req_cnt >= 0) begin
                    if (n != req_cnt) begin
                        $error("rect count: expected %0d, got %0d", req_cnt, n);
                        errors++;
                    end else if (n > 0) begin
                        k = pending_rects.size() - n;
                        pending_rects[k].x   = 9'(req_fx);
                        pending_rects[k].y   = 8'(req_fy);
                        pending_rects[k].w   = 4'(req_fw);
                        pending_rects[k].h   = 4'(req_fh);
                        pending_rects[k].vis = 1'(req_fv);
                    end
                end
            end
            if (m_valid && m_ready) begin
                rect_beats++;
                if (!m_visible) hidden_beats++;
                if (pending_rects.size() == 0) begin
                    $error("rectangle beat with nothing expected");
                    errors++;
                end else begin
                    want = pending_rects.pop_front();
                    check_field("rect_x", want.x, m_rect_x);
                    check_field("rect_y", want.y, m_rect_y);
                    check_field("rect_w", want.w, m_rect_w);
                    check_field("rect_h", want.h, m_rect_h);
                    check_field("fill_ink", want.ink, m_fill_ink);
                    check_field("visible", want.vis, m_visible);
                    check_field("last", want.last, m_last);
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long_req) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_long_req = 1'b0;
                m_ready = 1'b1;
            end else if (!wind_down && $urandom_range(0, 7) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    task automatic send_draw(int code, int ox, int oy, int ink, int scale);
        s_char_code = 8'(code);
        s_origin_x  = 12'(ox);
        s_origin_y  = 12'(oy);
        s_ink       = 8'(ink);
        s_scale     = 4'(scale);
        s_valid     = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic idle_gap();
        if (!wind_down && $urandom_range(0, 3) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    initial begin
        int code, ox, oy, scale, pick;
        s_valid     = 1'b0;
        s_char_code = '0;
        s_origin_x  = '0;
        s_origin_y  = '0;
        s_ink       = '0;
        s_scale     = '0;
        req_cnt     = -1;
        aresetn     = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (draw_rows[i]) begin
            req_cnt = draw_rows[i].cnt;
            req_fx  = draw_rows[i].fx;
            req_fy  = draw_rows[i].fy;
            req_fw  = draw_rows[i].fw;
            req_fh  = draw_rows[i].fh;
            req_fv  = draw_rows[i].fv;
            if (draw_rows[i].cnt == 0) unknown_reqs++;
            else glyph_reqs++;
            send_draw(draw_rows[i].code, draw_rows[i].ox, draw_rows[i].oy,
                      draw_rows[i].ink, draw_rows[i].scale);
            idle_gap();
        end

        req_cnt = -1;
        while (glyph_reqs < RANDOM_GLYPHS) begin
            if ($urandom_range(0, 7) == 0) begin
                code = $urandom_range(0, 255);
                // fold font codes into the upper half, which holds none
                if ((code >= "A" && code <= "Z") || (code >= "0" && code <= "9"))
                    code = code ^ 8'h80;
                unknown_reqs++;
            end else begin
                pick = $urandom_range(0, 35);
                code = (pick < 26) ? "A" + pick : "0" + pick - 26;
                glyph_reqs++;
                if (glyph_reqs == 120) hold_long_req = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                ox = $signed(12'($urandom));
                oy = $signed(12'($urandom));
            end else if (pick < 4) begin
                ox = int'($urandom_range(0, 440)) - 60;
                oy = int'($urandom_range(0, 320)) - 60;
            end else begin
                ox = $urandom_range(0, 300);
                oy = $urandom_range(0, 180);
            end
            pick = $urandom_range(0, 19);
            if (pick == 0) scale = 0;
            else if (pick == 1) scale = $urandom_range(9, 15);
            else scale = $urandom_range(1, 8);
            wind_down = (glyph_reqs >= RANDOM_GLYPHS - 50);
            send_draw(code, ox, oy, $urandom_range(0, 255), scale);
            idle_gap();
        end
        s_valid = 1'b0;

        while (pending_rects.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);

        $display("%0d glyph requests over %0d of 36 characters, %0d unknown codes",
                 glyph_reqs, $countones(glyphs_seen), unknown_reqs);
        $display("%0d rectangle beats checked, %0d of them fully clipped",
                 rect_beats, hidden_beats);
        if (errors == 0) begin
            $display("scaled_glyph_rasterizer_tb: done, clean");
        end else begin
            $display("scaled_glyph_rasterizer_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #(12_000_000);
        $display("timeout");
        $display("scaled_glyph_rasterizer_tb: done, errors");
        $finish;
    end

endmodule
